@@ rtl/tbhvc_pkg.sv @@
// tbhvc_pkg: shared types and constants for the take-back-half velocity controller
// fixed-point format, register map, sequencer states and shared multiplier ops
// no dependencies
package tbhvc_pkg;

   localparam int FRACTION_BITS = 24;
   localparam int DRIVE_W       = FRACTION_BITS + 1;
   localparam int TARGET_W      = 12;
   localparam int SAMPLE_W      = 13;
   localparam int ERR_W         = 14;
   localparam int GAIN_W        = 24;
   localparam int PCT_W         = 14;
   localparam int MUL_A_W       = 15;
   localparam int MUL_B_W       = DRIVE_W + 1;
   localparam int PROD_W        = MUL_A_W + MUL_B_W;
   localparam int SUM_W         = PROD_W + 1;
   localparam int SCALED_W      = PROD_W - FRACTION_BITS;

   localparam logic [DRIVE_W-1:0] DRIVE_ONE = DRIVE_W'(64'd1 << FRACTION_BITS);
   localparam longint GAIN_RESET_L = ((64'd1 << FRACTION_BITS) * 25 + 5000) / 10000;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(GAIN_RESET_L);

   localparam logic [MUL_A_W-1:0]  PCT_SCALE  = MUL_A_W'(10000);
   localparam logic [SCALED_W-1:0] PCT_OFFSET = SCALED_W'(50);
   localparam logic [SCALED_W-1:0] PCT_MAX    = SCALED_W'(10000);
   localparam logic [PROD_W-1:0]   PCT_HALF   = PROD_W'(64'd1 << (FRACTION_BITS - 1));

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] CSR_IDX_TARGET = 2'd0;
   localparam logic [1:0] CSR_IDX_APPROX = 2'd1;
   localparam logic [1:0] CSR_IDX_GAIN   = 2'd2;

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [DRIVE_W-1:0]  approx;
      logic [GAIN_W-1:0]   gain;
      logic                target_load;
      logic [TARGET_W-1:0] target_wdata;
   } cfg_type;

   typedef enum logic [1:0] {
      MUL_HOLD,
      MUL_GAIN,
      MUL_SCALE
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_ERR,
      ST_ACCUM,
      ST_CROSS,
      ST_MUL_PCT,
      ST_SCALE
   } state_type;

endpackage

@@ rtl/tbhvc_csr.sv @@
// tbhvc_csr: apb register file for target, drive approximation and loop gain
// depends on tbhvc_pkg
module tbhvc_csr import tbhvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [TARGET_W-1:0] target_ff, target_in;
   logic [DRIVE_W-1:0]  approx_ff, approx_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic                wr_en;
   logic [1:0]          idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[3:2];

   always_comb begin
      target_in = target_ff;
      approx_in = approx_ff;
      gain_in   = gain_ff;
      if (wr_en) begin
         case (idx)
            CSR_IDX_TARGET: target_in = csr_pwdata[TARGET_W-1:0];
            CSR_IDX_APPROX: approx_in = csr_pwdata[DRIVE_W-1:0];
            CSR_IDX_GAIN:   gain_in   = csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         approx_ff <= '0;
         gain_ff   <= GAIN_RESET;
      end else begin
         target_ff <= target_in;
         approx_ff <= approx_in;
         gain_ff   <= gain_in;
      end
   end

   always_comb begin
      case (idx)
         CSR_IDX_TARGET: csr_prdata = CSR_DATA_W'(target_ff);
         CSR_IDX_APPROX: csr_prdata = CSR_DATA_W'(approx_ff);
         CSR_IDX_GAIN:   csr_prdata = CSR_DATA_W'(gain_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.target       = target_ff;
   assign cfg.approx       = approx_ff;
   assign cfg.gain         = gain_ff;
   assign cfg.target_load  = wr_en && (idx == CSR_IDX_TARGET);
   assign cfg.target_wdata = csr_pwdata[TARGET_W-1:0];

endmodule

@@ rtl/tbhvc_mul.sv @@
// tbhvc_mul: shared signed multiplier with registered product
// forms error times gain, then drive times percent scale
// depends on tbhvc_pkg
module tbhvc_mul import tbhvc_pkg::*; (
   input  logic                     clock,
   input  mul_op_type               op,
   input  logic signed [ERR_W-1:0]  err,
   input  logic [GAIN_W-1:0]        gain,
   input  logic [DRIVE_W-1:0]       drive,
   output logic signed [PROD_W-1:0] product
);

   logic signed [MUL_A_W-1:0] a;
   logic signed [MUL_B_W-1:0] b;
   logic signed [PROD_W-1:0]  product_ff, product_in;

   always_comb begin
      case (op)
         MUL_GAIN: begin
            a = MUL_A_W'(err);
            b = $signed(MUL_B_W'(gain));
         end
         MUL_SCALE: begin
            a = $signed(PCT_SCALE);
            b = $signed(MUL_B_W'(drive));
         end
         default: begin
            a = '0;
            b = '0;
         end
      endcase
      product_in = (op == MUL_HOLD) ? product_ff : PROD_W'(a * b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ rtl/take_back_half_velocity_controller.sv @@
// take_back_half_velocity_controller: take-back-half flywheel speed regulator
// sequencer, controller state and output register around the shared multiplier
// depends on tbhvc_pkg, tbhvc_csr, tbhvc_mul
//
// usage:
//   req channel carries one measured velocity sample (13-bit signed rpm).
//   rsp channel returns one result per sample: motor percent in hundredths,
//   drive level in Q1.24 and a flag for a target crossing.
//   csr port is apb: target velocity at 0x0, drive approximation at 0x4,
//   loop gain at 0x8; writing the target re-arms the first-crossing load.
// timing:
//   a sample is taken in idle, then the block steps through error multiply,
//   accumulate and clamp, crossing update, percent multiply and scaling,
//   taking no new sample until it is back in idle; req_stall is high meanwhile.
//   the single multiplier is used twice per sample.
//   the result sits in an output register; the next sample can be taken
//   while it waits, but the block holds in the scaling step when the output
//   register is still full and rsp_stall is high.
// reset: synchronous, clears all controller state and the output valid;
//   loop gain resets to 0.0025 of full drive.
module take_back_half_velocity_controller import tbhvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_measured_velocity,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PCT_W-1:0]      rsp_motor_percent,
   output logic [DRIVE_W-1:0]    rsp_drive_level,
   output logic                  rsp_crossed_target,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type                  cfg;
   mul_op_type               mul_op;
   logic signed [PROD_W-1:0] product;

   state_type state_ff, state_in;

   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [DRIVE_W-1:0]         acc_ff, acc_in;
   logic                       crossed_ff, crossed_in;

   logic [DRIVE_W-1:0]         drive_ff, drive_in;
   logic [DRIVE_W-1:0]         saved_ff, saved_in;
   logic                       prev_neg_ff, prev_neg_in;
   logic                       first_ff, first_in;
   logic signed [SAMPLE_W-1:0] last_ff, last_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]           pct_ff, pct_in;
   logic [DRIVE_W-1:0]         out_drive_ff, out_drive_in;
   logic                       out_crossed_ff, out_crossed_in;

   logic                       req_xfer;
   logic                       out_free;
   logic signed [SUM_W-1:0]    sum;
   logic [DRIVE_W:0]           avg_sum;
   logic [PROD_W-1:0]          rounded;
   logic [SCALED_W-1:0]        pct_raw;
   logic                       crossed;

   tbhvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tbhvc_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .err     (err_ff),
      .gain    (cfg.gain),
      .drive   (drive_ff),
      .product (product)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign crossed   = err_ff[ERR_W-1] != prev_neg_ff;
   assign sum       = $signed(SUM_W'(drive_ff)) + SUM_W'(product);
   assign avg_sum   = {1'b0, acc_ff} + {1'b0, saved_ff};
   assign rounded   = product + PCT_HALF;
   assign pct_raw   = rounded[PROD_W-1:FRACTION_BITS] + PCT_OFFSET;

   always_comb begin
      state_in       = state_ff;
      mul_op         = MUL_HOLD;
      err_in         = err_ff;
      sample_in      = sample_ff;
      acc_in         = acc_ff;
      crossed_in     = crossed_ff;
      drive_in       = drive_ff;
      saved_in       = saved_ff;
      prev_neg_in    = prev_neg_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      pct_in         = pct_ff;
      out_drive_in   = out_drive_ff;
      out_crossed_in = out_crossed_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sample_in = $signed(req_measured_velocity);
               err_in    = $signed(ERR_W'(cfg.target))
                           - ERR_W'($signed(req_measured_velocity));
               state_in  = ST_MUL_ERR;
            end
         end
         ST_MUL_ERR: begin
            mul_op   = MUL_GAIN;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (sum > $signed(SUM_W'(DRIVE_ONE))) begin
               acc_in = DRIVE_ONE;
            end else if (sum[SUM_W-1]) begin
               acc_in = '0;
            end else begin
               acc_in = sum[DRIVE_W-1:0];
            end
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            drive_in = acc_ff;
            if (crossed) begin
               if (first_ff) begin
                  drive_in = (cfg.approx > DRIVE_ONE) ? DRIVE_ONE : cfg.approx;
                  first_in = 1'b0;
               end else begin
                  drive_in = avg_sum[DRIVE_W:1];
               end
               saved_in = drive_in;
            end
            crossed_in  = crossed;
            prev_neg_in = err_ff[ERR_W-1];
            last_in     = sample_ff;
            state_in    = ST_MUL_PCT;
         end
         ST_MUL_PCT: begin
            mul_op   = MUL_SCALE;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               pct_in         = (pct_raw > PCT_MAX) ? PCT_W'(PCT_MAX) : pct_raw[PCT_W-1:0];
               out_drive_in   = drive_ff;
               out_crossed_in = crossed_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cfg.target_load) begin
         first_in    = 1'b1;
         saved_in    = '0;
         prev_neg_in = $signed({2'b00, cfg.target_wdata}) < ERR_W'(last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drive_ff     <= '0;
         saved_ff     <= '0;
         prev_neg_ff  <= 1'b0;
         first_ff     <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drive_ff     <= drive_in;
         saved_ff     <= saved_in;
         prev_neg_ff  <= prev_neg_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff         <= err_in;
      sample_ff      <= sample_in;
      acc_ff         <= acc_in;
      crossed_ff     <= crossed_in;
      pct_ff         <= pct_in;
      out_drive_ff   <= out_drive_in;
      out_crossed_ff <= out_crossed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_percent  = pct_ff;
   assign rsp_drive_level    = out_drive_ff;
   assign rsp_crossed_target = out_crossed_ff;

endmodule

@@ sim/take_back_half_velocity_controller_test.sv @@
// take_back_half_velocity_controller_test: self-checking bench for the take-back-half regulator
// drives speed samples and apb register writes, predicts each result and compares it
// depends on tbhvc_pkg and the take_back_half_velocity_controller rtl
`timescale 1ns / 100ps

module take_back_half_velocity_controller_test;
   import tbhvc_pkg::*;

   localparam logic [1:0] CSR_IDX_UNUSED = 2'd3;

   typedef struct packed {
      logic [PCT_W-1:0]   motor_percent;
      logic [DRIVE_W-1:0] drive_level;
      logic               crossed_target;
   } regulator_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_measured_velocity = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PCT_W-1:0]      rsp_motor_percent;
   logic [DRIVE_W-1:0]    rsp_drive_level;
   logic                  rsp_crossed_target;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // regulator mirror
   logic [TARGET_W-1:0]        target_speed;
   logic [DRIVE_W-1:0]         approx_drive;
   logic [GAIN_W-1:0]          gain;
   logic [DRIVE_W-1:0]         drive_now;
   logic [DRIVE_W-1:0]         drive_at_crossing;
   logic                       error_was_negative;
   logic                       first_crossing_armed;
   logic signed [SAMPLE_W-1:0] prior_sample;

   regulator_result_type pending_results[$];
   int                   mismatch_count = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;

   take_back_half_velocity_controller uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_measured_velocity(req_measured_velocity),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_motor_percent(rsp_motor_percent),
      .rsp_drive_level(rsp_drive_level),
      .rsp_crossed_target(rsp_crossed_target),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic regulator_result_type advance_regulator(
      input logic signed [SAMPLE_W-1:0] measured);
      longint               speed_error;
      longint               sum;
      longint               percent;
      logic                 negative;
      logic                 crossed;
      logic [DRIVE_W-1:0]   drive;
      regulator_result_type res;
      speed_error = longint'(target_speed) - longint'(measured);
      sum = longint'(drive_now) + speed_error * longint'(gain);
      if (sum > longint'(DRIVE_ONE)) sum = longint'(DRIVE_ONE);
      if (sum < 0) sum = 0;
      drive = DRIVE_W'(sum);
      negative = (speed_error < 0);
      crossed = (negative != error_was_negative);
      if (crossed) begin
         if (first_crossing_armed) begin
            drive = (approx_drive > DRIVE_ONE) ? DRIVE_ONE : approx_drive;
            first_crossing_armed = 1'b0;
         end else begin
            drive = DRIVE_W'((longint'(drive) + longint'(drive_at_crossing)) >> 1);
         end
         drive_at_crossing = drive;
      end
      drive_now = drive;
      error_was_negative = negative;
      prior_sample = measured;
      percent = ((longint'(drive) * 10000 + (longint'(1) << (FRACTION_BITS - 1)))
                 >> FRACTION_BITS) + 50;
      if (percent > 10000) percent = 10000;
      res.motor_percent = PCT_W'(percent);
      res.drive_level = drive;
      res.crossed_target = crossed;
      return res;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip_speed(input longint v);
      if (v > 4095) return SAMPLE_W'(4095);
      if (v < -4096) return SAMPLE_W'(-4096);
      return SAMPLE_W'(v);
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] measured);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_measured_velocity <= measured;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(advance_regulator(measured));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         CSR_IDX_TARGET: begin
            target_speed = value[TARGET_W-1:0];
            first_crossing_armed = 1'b1;
            drive_at_crossing = '0;
            error_was_negative = (longint'(target_speed) - longint'(prior_sample)) < 0;
         end
         CSR_IDX_APPROX: approx_drive = value[DRIVE_W-1:0];
         CSR_IDX_GAIN:   gain = value[GAIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // results are checked in transfer order against the oldest prediction
   always @(posedge clock) begin
      regulator_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result pct=%0d drive=%0d crossed=%0d", $time,
                     rsp_motor_percent, rsp_drive_level, rsp_crossed_target);
         end else begin
            want = pending_results.pop_front();
            if (rsp_motor_percent !== want.motor_percent) begin
               mismatch_count++;
               $display("%0t: motor_percent expected %0d actual %0d", $time,
                        want.motor_percent, rsp_motor_percent);
            end
            if (rsp_drive_level !== want.drive_level) begin
               mismatch_count++;
               $display("%0t: drive_level expected %0d actual %0d", $time,
                        want.drive_level, rsp_drive_level);
            end
            if (rsp_crossed_target !== want.crossed_target) begin
               mismatch_count++;
               $display("%0t: crossed_target expected %0d actual %0d", $time,
                        want.crossed_target, rsp_crossed_target);
            end
         end
      end
   end

   // crossing right after reset averages with a zero saved drive
   task automatic test_power_up_crossing();
      send_idle_pct = 0;
      stall_pct = 0;
      send_sample(SAMPLE_W'(0));
      send_sample(SAMPLE_W'(1));
      send_sample(SAMPLE_W'(-4096));
      send_sample(SAMPLE_W'(-1));
      send_sample(SAMPLE_W'(4095));
      wait_drained();
   endtask

   task automatic test_register_extremes();
      write_register(CSR_IDX_UNUSED, 32'h00ff_ffff);
      write_register(CSR_IDX_GAIN, 32'h00ff_ffff);
      write_register(CSR_IDX_APPROX, 32'h01ff_ffff);
      write_register(CSR_IDX_TARGET, 32'd4095);
      send_sample(SAMPLE_W'(-4096));
      send_sample(SAMPLE_W'(4095));
      wait_drained();
      // oversized approximation saturates on the first crossing
      write_register(CSR_IDX_TARGET, 32'd0);
      send_sample(SAMPLE_W'(4095));
      send_sample(SAMPLE_W'(-4096));
      send_sample(SAMPLE_W'(0));
      send_sample(SAMPLE_W'(1));
      wait_drained();
      write_register(CSR_IDX_GAIN, 32'd0);
      write_register(CSR_IDX_APPROX, 32'h0100_0000);
      write_register(CSR_IDX_TARGET, 32'd2048);
      send_sample(SAMPLE_W'(2049));
      send_sample(SAMPLE_W'(2048));
      send_sample(SAMPLE_W'(2047));
      wait_drained();
      write_register(CSR_IDX_GAIN, 32'(GAIN_RESET));
      write_register(CSR_IDX_APPROX, 32'h0080_0000);
      write_register(CSR_IDX_TARGET, 32'd1000);
      send_sample(SAMPLE_W'(900));
      send_sample(SAMPLE_W'(1001));
      send_sample(SAMPLE_W'(999));
      send_sample(SAMPLE_W'(1000));
      send_sample(SAMPLE_W'(1100));
      send_sample(SAMPLE_W'(950));
      wait_drained();
   endtask

   task automatic load_random_settings();
      int                  pick;
      logic [CSR_DATA_W-1:0] value;
      pick = $urandom_range(0, 9);
      value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h00ff_ffff :
              (pick < 6) ? 32'(GAIN_RESET) + $urandom_range(0, 60000) :
              (pick < 9) ? $urandom_range(1, 400000) : $urandom_range(0, 32'h00ff_ffff);
      write_register(CSR_IDX_GAIN, value);
      pick = $urandom_range(0, 9);
      value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h0100_0000 :
              (pick == 2) ? 32'h01ff_ffff : $urandom_range(0, 32'h0100_0000);
      write_register(CSR_IDX_APPROX, value);
      if ($urandom_range(0, 9) == 0) write_register(CSR_IDX_UNUSED, $urandom());
      pick = $urandom_range(0, 9);
      value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd4095 : $urandom_range(0, 4095);
      write_register(CSR_IDX_TARGET, value);
   endtask

   // mostly ramps and dithering across the target, some full-range noise
   task automatic send_random_stretch(input int count);
      int     sent;
      int     kind;
      int     len;
      int     span;
      int     dir;
      longint base;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         len = $urandom_range(4, 16);
         span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) :
                ($urandom_range(0, 1) == 0) ? $urandom_range(8, 128) : $urandom_range(128, 2048);
         dir = ($urandom_range(0, 1) == 0) ? 1 : -1;
         base = longint'(target_speed);
         for (int i = 0; i < len && sent < count; i++) begin
            if (kind < 55)
               send_sample(clip_speed(base + dir * (-span + (2 * span * i) / (len - 1))
                                      + longint'($urandom_range(0, 4)) - 2));
            else if (kind < 85)
               send_sample(clip_speed(base + longint'($urandom_range(0, 2 * span)) - span));
            else
               send_sample(SAMPLE_W'($urandom_range(0, 8191)));
            sent++;
         end
      end
   endtask

   task automatic test_random_regulation();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         for (int k = 0; k < 5; k++) begin
            load_random_settings();
            send_random_stretch(58);
            wait_drained();
         end
      end
   endtask

   initial begin
      target_speed = '0;
      approx_drive = '0;
      gain = GAIN_RESET;
      drive_now = '0;
      drive_at_crossing = '0;
      error_was_negative = 1'b0;
      first_crossing_armed = 1'b0;
      prior_sample = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_power_up_crossing();
      test_register_extremes();
      test_random_regulation();
      send_idle_pct = 0;
      stall_pct = 0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tbhvc_pkg.sv
rtl/tbhvc_csr.sv
rtl/tbhvc_mul.sv
rtl/take_back_half_velocity_controller.sv
sim/take_back_half_velocity_controller_test.sv
